// ===== hw/rtl/pdt_pkg.sv =====
package pdt_pkg;

    localparam int FRAC_BITS_DEF = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // shared multiplier: 34-bit signed operand by 17-bit signed half word
    localparam int OPA_W  = 34;
    localparam int HALF_W = 16;
    localparam int PROD_W = OPA_W + HALF_W + 1;
    localparam int ACC_W  = 66;

    localparam logic [30:0] PROP_GAIN_RST      = 31'd251658240;
    localparam logic [30:0] DERIV_GAIN_RST     = 31'd13421773;
    localparam logic [30:0] ACCEL_GAIN_RST     = 31'd167772160;
    localparam logic [24:0] STEP_TIME_RST      = 25'd16777;
    localparam logic [15:0] PUBLISH_PERIOD_RST = 16'd10;

    typedef struct packed {
        logic               loop_active;
        logic signed [31:0] target_position;
        logic [31:0]        tick_ms;
    } t_in_item;

    typedef struct packed {
        logic signed [25:0] loop_effort;
        logic               saturated;
        logic signed [31:0] plant_position;
        logic signed [31:0] plant_velocity;
        logic [31:0]        stamp_ms;
        logic               publish_now;
    } t_out_item;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN,
        CFG_DERIV_GAIN,
        CFG_ACCEL_GAIN,
        CFG_STEP_TIME,
        CFG_PUBLISH_PERIOD
    } t_cfg_idx;

    // products in evaluation order
    typedef enum logic [2:0] {
        PR_P,
        PR_D,
        PR_A,
        PR_V,
        PR_X
    } t_prod;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL_LO,
        DP_MUL_HI,
        DP_ACC,
        DP_FOLD,
        DP_EMIT
    } t_dp_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_FOLD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_dp_op op;
        t_prod  prod;
    } t_dp_cmd;

    typedef struct packed {
        logic in_active;
        logic rem_done;
    } t_dp_sts;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W:0] x);
        logic fits;
        fits = (&x[ACC_W:31]) || (~|x[ACC_W:31]);
        if (fits) begin
            return x[31:0];
        end else if (x[ACC_W]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

endpackage

// ===== hw/rtl/pdt_rem.sv =====
module pdt_rem import pdt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic        o_zero
);

    // restoring remainder, two dividend bits per cycle
    localparam int STEPS = 16;
    localparam int CNT_W = $clog2(STEPS);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_num;
    logic [15:0]      r_rem;
    logic [15:0]      r_div;

    logic [16:0] t1;
    logic [16:0] t2;
    logic [15:0] r1;
    logic [15:0] r2;

    always_comb begin
        t1 = {r_rem, r_num[31]};
        r1 = (t1 >= {1'b0, r_div}) ? 16'(t1 - {1'b0, r_div}) : t1[15:0];
        t2 = {r1, r_num[30]};
        r2 = (t2 >= {1'b0, r_div}) ? 16'(t2 - {1'b0, r_div}) : t2[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[29:0], 2'b00};
            r_rem <= r2;
        end
    end

    assign o_done = !r_busy;
    assign o_zero = (r_rem == '0) && (r_div != '0);

endmodule

// ===== hw/rtl/pdt_dp.sv =====
module pdt_dp import pdt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  t_in_item              i_in_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_out_item             o_out_data
);

    localparam logic signed [ACC_W:0] ONE_WIDE =
        {{(ACC_W - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [ACC_W:0] NEG_ONE_WIDE = -ONE_WIDE;
    localparam logic signed [31:0] ONE_EFF =
        {{(31 - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [31:0] NEG_ONE_EFF = -ONE_EFF;

    logic [30:0] r_prop;
    logic [30:0] r_deriv;
    logic [30:0] r_accel;
    logic [24:0] r_step;
    logic [15:0] r_period;

    logic signed [31:0] r_pos;
    logic signed [31:0] r_vel;
    logic               r_sat;

    logic signed [31:0]       r_target;
    logic [31:0]              r_tick;
    logic signed [31:0]       r_eff;
    logic signed [31:0]       r_a;
    logic signed [ACC_W-1:0]  r_p;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    t_out_item                r_out;

    logic signed [32:0]       err;
    logic signed [OPA_W-1:0]  opa;
    logic [30:0]              opb;
    logic [HALF_W-1:0]        half;
    logic signed [HALF_W:0]   b_part;
    logic signed [PROD_W-1:0] mul;
    logic signed [ACC_W-1:0]  sh;
    logic signed [ACC_W:0]    diff;
    logic signed [31:0]       base;
    logic signed [ACC_W:0]    wsum;
    logic                     rem_done;
    logic                     rem_zero;

    always_comb begin
        err = 33'(r_target) - 33'(r_pos);
        unique case (i_cmd.prod)
            PR_P: begin
                opa = OPA_W'(err);
                opb = r_prop;
            end
            PR_D: begin
                opa = OPA_W'(r_vel);
                opb = r_deriv;
            end
            PR_A: begin
                opa = OPA_W'(r_eff);
                opb = r_accel;
            end
            PR_V: begin
                opa = OPA_W'(r_a);
                opb = {6'b0, r_step};
            end
            PR_X: begin
                opa = OPA_W'(r_vel);
                opb = {6'b0, r_step};
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
        half   = (i_cmd.op == DP_MUL_HI) ? {1'b0, opb[30:16]} : opb[15:0];
        b_part = signed'({1'b0, half});
        mul    = opa * b_part;
        sh     = r_acc >>> FRAC_BITS;
        diff   = (ACC_W + 1)'(r_p) - (ACC_W + 1)'(sh);
        base   = (i_cmd.prod == PR_V) ? r_vel : r_pos;
        wsum   = (ACC_W + 1)'(base) + (ACC_W + 1)'(sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop   <= PROP_GAIN_RST;
            r_deriv  <= DERIV_GAIN_RST;
            r_accel  <= ACCEL_GAIN_RST;
            r_step   <= STEP_TIME_RST;
            r_period <= PUBLISH_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:      r_prop   <= i_cfg_data[30:0];
                CFG_DERIV_GAIN:     r_deriv  <= i_cfg_data[30:0];
                CFG_ACCEL_GAIN:     r_accel  <= i_cfg_data[30:0];
                CFG_STEP_TIME:      r_step   <= i_cfg_data[24:0];
                CFG_PUBLISH_PERIOD: r_period <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // plant state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_vel <= '0;
            r_sat <= 1'b0;
        end else if (i_cmd.op == DP_FOLD) begin
            unique case (i_cmd.prod)
                PR_D: begin
                    r_sat <= (diff > ONE_WIDE) || (diff < NEG_ONE_WIDE);
                end
                PR_V:    r_vel <= sat32(wsum);
                PR_X:    r_pos <= sat32(wsum);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_target <= i_in_data.target_position;
                r_tick   <= i_in_data.tick_ms;
                r_eff    <= '0;
            end
            DP_MUL_LO: begin
                r_prod <= mul;
            end
            DP_MUL_HI: begin
                r_prod <= mul;
                r_acc  <= ACC_W'(r_prod);
            end
            DP_ACC: begin
                r_acc <= r_acc + (ACC_W'(r_prod) <<< HALF_W);
            end
            DP_FOLD: begin
                unique case (i_cmd.prod)
                    PR_P: r_p <= sh;
                    PR_D: begin
                        if (diff > ONE_WIDE) begin
                            r_eff <= ONE_EFF;
                        end else if (diff < NEG_ONE_WIDE) begin
                            r_eff <= NEG_ONE_EFF;
                        end else begin
                            r_eff <= diff[31:0];
                        end
                    end
                    PR_A:    r_a <= sh[31:0];
                    default: ;
                endcase
            end
            DP_EMIT: begin
                r_out.loop_effort    <= r_eff[25:0];
                r_out.saturated      <= r_sat;
                r_out.plant_position <= r_pos;
                r_out.plant_velocity <= r_vel;
                r_out.stamp_ms       <= r_tick;
                r_out.publish_now    <= rem_zero;
            end
            default: ;
        endcase
    end

    pdt_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == DP_LOAD),
        .i_dividend (i_in_data.tick_ms),
        .i_divisor  (r_period),
        .o_done     (rem_done),
        .o_zero     (rem_zero)
    );

    assign o_sts.in_active = i_in_data.loop_active;
    assign o_sts.rem_done  = rem_done;
    assign o_out_data      = r_out;

endmodule

// ===== hw/rtl/pdt_ctrl.sv =====
module pdt_ctrl import pdt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    t_prod  r_prod;
    t_prod  n_prod;
    logic   r_out_vld;
    logic   n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_prod    <= PR_P;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_prod    <= n_prod;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_prod     = r_prod;
        n_out_vld  = r_out_vld && i_out_stall;
        o_cmd.op   = DP_NOP;
        o_cmd.prod = r_prod;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_prod   = PR_P;
                    n_state  = i_sts.in_active ? ST_MUL_LO : ST_EMIT;
                end
            end
            ST_MUL_LO: begin
                o_cmd.op = DP_MUL_LO;
                n_state  = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                o_cmd.op = DP_MUL_HI;
                n_state  = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.op = DP_ACC;
                n_state  = ST_FOLD;
            end
            ST_FOLD: begin
                o_cmd.op = DP_FOLD;
                n_state  = ST_MUL_LO;
                unique case (r_prod)
                    PR_P:    n_prod = PR_D;
                    PR_D:    n_prod = PR_A;
                    PR_A:    n_prod = PR_V;
                    PR_V:    n_prod = PR_X;
                    default: n_state = ST_EMIT;
                endcase
            end
            ST_EMIT: begin
                if (i_sts.rem_done && (!r_out_vld || !i_out_stall)) begin
                    o_cmd.op  = DP_EMIT;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

// ===== hw/rtl/pd_loop_with_plant_twin.sv =====
// channel  direction  handshake              payload
// in       to block   i_in_valid/o_in_stall   t_in_item   (active, target, tick)
// out      from block o_out_valid/i_out_stall t_out_item  (effort, flags, plant, stamp)
// cfg      to block   i_cfg_valid/o_cfg_ready index + 32-bit data, always ready
//
// Active item: five products on one shared 34x17 multiplier, each through low-half
// multiply, high-half multiply, accumulate and fold, between load and emit.
// Inactive item: load then emit, with emit held for the two-bit-per-cycle remainder
// unit for the publish check, which runs alongside; emit also waits on a stalled output.
// One item in flight; the next is taken once the result sits in the output
// register. Synchronous reset loads register defaults and clears the plant.
module pd_loop_with_plant_twin import pdt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    pdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pdt_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule
